// ===== rtl/command_frame_validator_unit_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros for the command frame validator
// Shorthand for clocked, reset-gated implication checks.
// ------------------------------------------------------------------------
`ifndef COMMAND_FRAME_VALIDATOR_UNIT_MACROS_SVH
`define COMMAND_FRAME_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define CFV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cfv assertion failed");

// Next-cycle implication.
`define CFV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cfv assertion failed");

`endif

// ===== rtl/cfv_pkg.sv =====
// ------------------------------------------------------------------------
// cfv_pkg
// Types, codes and constants shared by the command frame validator.
// ------------------------------------------------------------------------
`default_nettype none

package cfv_pkg;

	typedef logic [7:0] byte_t;

	localparam int BODY_DEPTH = 8;
	localparam int BODY_KEEP  = 5;
	localparam int CNT_W      = $clog2(BODY_DEPTH + 1);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int REG_IDX_W  = 1;

	localparam byte_t START_RESET = 8'd35;
	localparam byte_t END_RESET   = 8'd33;

	localparam byte_t CHAR_A = 8'h41;
	localparam byte_t CHAR_P = 8'h50;
	localparam byte_t CHAR_L = 8'h4C;
	localparam byte_t CHAR_R = 8'h52;
	localparam byte_t CHAR_T = 8'h74;
	localparam byte_t CHAR_H = 8'h68;
	localparam byte_t CHAR_C = 8'h63;
	localparam byte_t CHAR_0 = 8'h30;
	localparam byte_t CHAR_9 = 8'h39;

	localparam logic [9:0] K_HUNDRED = 10'd100;
	localparam logic [9:0] K_TEN     = 10'd10;

	localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(4);
	localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(5);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START = 1'b0,
		REG_END   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_INCOMPLETE = 3'd1,
		STAT_INVALID    = 3'd2,
		STAT_MISMATCH   = 3'd3,
		STAT_NONDIGIT   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_A = 2'd0,
		CMD_P = 2'd1,
		CMD_L = 2'd2,
		CMD_R = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		SENS_T = 2'd0,
		SENS_H = 2'd1,
		SENS_C = 2'd2
	} sensor_t;

	// Closed frame as handed from the front to the back.
	typedef struct packed {
		logic                            overflow;
		logic [CNT_W-1:0]                count;
		logic [BODY_KEEP-1:0][7:0]       body;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} push_t;

	// Status ends up in the low bits.
	typedef struct packed {
		byte_t    sum;
		sensor_t  sensor;
		command_t command;
		status_t  status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/cfv_front.sv =====
// ------------------------------------------------------------------------
// cfv_front
// Byte framing: tracks start/end symbols, gathers body bytes, closes frames.
// ------------------------------------------------------------------------
`default_nettype none

module cfv_front
	import cfv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire byte_t                s_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire byte_t                cfg_data,
	input  wire logic                 q_full,
	output push_t                     push
);

	logic                      in_frame_q;
	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	byte_t                     start_q;
	byte_t                     end_q;
	logic [BODY_KEEP-1:0][7:0] body_q;

	logic accept;
	logic is_start;
	logic is_end;
	logic body_beat;
	logic store;

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;

	assign accept    = s_tvalid && s_tready;
	assign is_start  = (s_tdata == start_q);
	assign is_end    = (s_tdata == end_q);
	assign body_beat = accept && !is_start && in_frame_q && !is_end;
	assign store     = body_beat && (count_q < CNT_W'(BODY_DEPTH));

	assign push.valid          = accept && !is_start && in_frame_q && is_end;
	assign push.frame.overflow = ovf_q;
	assign push.frame.count    = count_q;
	assign push.frame.body     = body_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				in_frame_q <= 1'b1;
				count_q    <= '0;
				ovf_q      <= 1'b0;
			end else if (in_frame_q && is_end) begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
				ovf_q      <= 1'b0;
			end else if (store) begin
				count_q <= count_q + CNT_W'(1);
			end else if (body_beat) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			end_q   <= END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START: start_q <= cfg_data;
				REG_END:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Only the leading bytes are ever checked; later body bytes just count.
	always_ff @(posedge clk) begin
		for (int i = 0; i < BODY_KEEP; i++) begin
			if (store && count_q == CNT_W'(i)) begin
				body_q[i] <= s_tdata;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cfv_queue.sv =====
// ------------------------------------------------------------------------
// cfv_queue
// Short FIFO of closed frames between the front and the back.
// ------------------------------------------------------------------------
`default_nettype none

module cfv_queue
	import cfv_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output logic       full,
	output logic       head_valid,
	output frame_t     head
);

	frame_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;
	logic                do_pop;

	assign full       = (fill_q == QCNT_W'(QDEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !push.valid) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.frame;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cfv_back.sv =====
// ------------------------------------------------------------------------
// cfv_back
// Frame checker: decodes command and sensor, checks digits and checksum,
// and holds the result in the output register.
// ------------------------------------------------------------------------
`default_nettype none

module cfv_back
	import cfv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   head_valid,
	input  wire frame_t head,
	output logic        pop,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output logic [15:0] m_tdata
);

	logic       out_valid_q;
	result_t    out_q;
	result_t    res;

	byte_t      b0;
	byte_t      sens_b;
	byte_t      d0;
	byte_t      d1;
	byte_t      d2;
	logic       known;
	logic       is_p;
	command_t   cmd;
	sensor_t    sens;
	logic       sens_ok;
	logic       digits_ok;
	logic [9:0] recv;
	byte_t      sum;

	always_comb begin
		b0     = head.body[0];
		sens_b = head.body[1];
		known  = head.count != '0;
		is_p   = 1'b0;
		cmd    = CMD_A;
		case (b0)
			CHAR_A: cmd = CMD_A;
			CHAR_L: cmd = CMD_L;
			CHAR_R: cmd = CMD_R;
			CHAR_P: begin
				cmd  = CMD_P;
				is_p = 1'b1;
			end
			default: known = 1'b0;
		endcase
		if (!known) begin
			cmd  = CMD_A;
			is_p = 1'b0;
		end

		sens    = SENS_T;
		sens_ok = 1'b1;
		case (sens_b)
			CHAR_T: sens = SENS_T;
			CHAR_H: sens = SENS_H;
			CHAR_C: sens = SENS_C;
			default: sens_ok = 1'b0;
		endcase

		// Checksum digits sit one byte later for P.
		d0 = is_p ? head.body[2] : head.body[1];
		d1 = is_p ? head.body[3] : head.body[2];
		d2 = is_p ? head.body[4] : head.body[3];
		digits_ok = (d0 >= CHAR_0) && (d0 <= CHAR_9) &&
			(d1 >= CHAR_0) && (d1 <= CHAR_9) &&
			(d2 >= CHAR_0) && (d2 <= CHAR_9);
		recv = {6'd0, d0[3:0]} * K_HUNDRED + {6'd0, d1[3:0]} * K_TEN + {6'd0, d2[3:0]};
		sum  = b0 + (is_p ? sens_b : 8'd0);

		res.command = cmd;
		res.sensor  = SENS_T;
		res.sum     = '0;
		if (head.overflow) begin
			res.status = STAT_INCOMPLETE;
		end else if (!known) begin
			res.status = STAT_INVALID;
		end else if (head.count != (is_p ? LEN_LONG : LEN_SHORT)) begin
			res.status = STAT_INCOMPLETE;
		end else if (is_p && !sens_ok) begin
			res.status = STAT_INVALID;
		end else begin
			res.sensor = is_p ? sens : SENS_T;
			if (!digits_ok) begin
				res.status = STAT_NONDIGIT;
			end else begin
				res.sum    = sum;
				res.status = (recv[7:0] == sum) ? STAT_OK : STAT_MISMATCH;
			end
		end
	end

	// Refill the output register when it is empty or being drained.
	assign pop = head_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire

// ===== rtl/command_frame_validator_unit.sv =====
// A result beat is offered on m_tvalid once the end-symbol beat is accepted and the
// closed frame has passed the queue write and then the output register load.
// Throughput: one byte per cycle; s_tready drops only while the two-entry frame
// queue is full behind a stalled output.
// Reset: clears framing state, queue and output valid; start and end symbols
// return to '#' and '!'.
// ------------------------------------------------------------------------
// command_frame_validator_unit
// Framed command checker: front framing, frame queue, back checker.
// ------------------------------------------------------------------------
`default_nettype none

module command_frame_validator_unit
	import cfv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [15:0]               m_tdata,   // [2:0] status, [4:3] command,
	                                             // [6:5] sensor, [14:7] sum_computed
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	push_t  push;
	logic   q_full;
	logic   head_valid;
	frame_t head;
	logic   pop;

	cfv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push)
	);

	cfv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	cfv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/cfv_checker.sv =====
// ------------------------------------------------------------------------
// cfv_checker
// Port-level checks on the result stream of the command frame validator.
// ------------------------------------------------------------------------
`default_nettype none

`include "command_frame_validator_unit_macros.svh"

module cfv_checker
	import cfv_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	logic [2:0] res_status;
	logic [1:0] res_command;
	logic [1:0] res_sensor;
	logic [7:0] res_sum;
	logic       cmp_reached;

	assign res_status  = m_tdata[2:0];
	assign res_command = m_tdata[4:3];
	assign res_sensor  = m_tdata[6:5];
	assign res_sum     = m_tdata[14:7];
	assign cmp_reached = (res_status == STAT_OK) || (res_status == STAT_MISMATCH);

	// A stalled result beat holds.
	`CFV_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	`CFV_ASSERT_IMP(a_status_range, clk, arst_n, m_tvalid, res_status <= STAT_NONDIGIT && !m_tdata[15])

	// Sensor is reported only for P commands.
	`CFV_ASSERT_IMP(a_sensor_p, clk, arst_n, m_tvalid && res_sensor != SENS_T, res_command == CMD_P)

	// A sum is reported only when the checksum comparison was reached.
	`CFV_ASSERT_IMP(a_sum_cmp, clk, arst_n, m_tvalid && res_sum != 8'd0, cmp_reached)

endmodule

bind command_frame_validator_unit cfv_checker u_cfv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/command_frame_validator_unit_check.sv =====
// ------------------------------------------------------------------------
// command_frame_validator_unit_check
// Watches the byte, result and register channels of the frame validator.
// Keeps its own framing state and symbol registers, works out the verdict
// of every closed frame and compares each result beat against the oldest
// verdict still due.
// ------------------------------------------------------------------------
module command_frame_validator_unit_check
	import cfv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [15:0]          m_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   mismatches,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	byte_t   open_sym;
	byte_t   close_sym;
	logic    framing;
	int      body_len;
	logic    body_ovf;
	byte_t   body_mem [BODY_DEPTH];
	result_t verdicts_due [$];

	function automatic logic is_digit(input byte_t b);
		return b >= CHAR_0 && b <= CHAR_9;
	endfunction

	// Verdict of the frame held in body_mem, checks in priority order.
	function automatic result_t judge_frame();
		result_t r;
		logic    known;
		logic    ok;
		int      need;
		int      lead;
		int      i;
		int      recv;
		byte_t   acc;
		r.status  = STAT_OK;
		r.command = CMD_A;
		r.sensor  = SENS_T;
		r.sum     = '0;
		known = 1'b0;
		need  = 4;
		lead  = 1;
		if (body_len >= 1) begin
			known = 1'b1;
			case (body_mem[0])
				CHAR_A: r.command = CMD_A;
				CHAR_P: begin
					r.command = CMD_P;
					need = 5;
					lead = 2;
				end
				CHAR_L: r.command = CMD_L;
				CHAR_R: r.command = CMD_R;
				default: known = 1'b0;
			endcase
		end
		if (body_ovf) begin
			r.status = STAT_INCOMPLETE;
		end else if (!known) begin
			r.status = STAT_INVALID;
		end else if (body_len != need) begin
			r.status = STAT_INCOMPLETE;
		end else begin
			ok = 1'b1;
			if (r.command == CMD_P) begin
				case (body_mem[1])
					CHAR_T: r.sensor = SENS_T;
					CHAR_H: r.sensor = SENS_H;
					CHAR_C: r.sensor = SENS_C;
					default: begin
						r.status = STAT_INVALID;
						ok = 1'b0;
					end
				endcase
			end
			for (i = lead; i < lead + 3; i++) begin
				if (ok && !is_digit(body_mem[i])) begin
					r.status = STAT_NONDIGIT;
					ok = 1'b0;
				end
			end
			if (ok) begin
				acc = '0;
				for (i = 0; i < lead; i++)
					acc = acc + body_mem[i];
				recv = 100 * (int'(body_mem[lead]) - int'(CHAR_0))
				     + 10 * (int'(body_mem[lead + 1]) - int'(CHAR_0))
				     + (int'(body_mem[lead + 2]) - int'(CHAR_0));
				r.sum    = acc;
				r.status = (recv[7:0] == acc) ? STAT_OK : STAT_MISMATCH;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t seen;
		result_t due;
		byte_t   b;
		if (!arst_n) begin
			open_sym  = START_RESET;
			close_sym = END_RESET;
			framing   = 1'b0;
			body_len  = 0;
			body_ovf  = 1'b0;
			verdicts_due.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			// Retire results first: a result beat never belongs to a frame closing now.
			if (m_tvalid && m_tready) begin
				seen = result_t'(m_tdata[14:0]);
				if (verdicts_due.size() == 0) begin
					$error("result beat with no frame verdict due");
					mismatches++;
				end else begin
					due = verdicts_due.pop_front();
					if (seen.status != due.status) begin
						$error("status: expected %0d, got %0d", due.status, seen.status);
						mismatches++;
					end
					if (seen.command != due.command) begin
						$error("command: expected %0d, got %0d", due.command, seen.command);
						mismatches++;
					end
					if (seen.sensor != due.sensor) begin
						$error("sensor: expected %0d, got %0d", due.sensor, seen.sensor);
						mismatches++;
					end
					if (seen.sum != due.sum) begin
						$error("sum_computed: expected %0d, got %0d", due.sum, seen.sum);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_START: open_sym  = cfg_data;
					REG_END:   close_sym = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				b = s_tdata;
				if (b == open_sym) begin
					framing  = 1'b1;
					body_len = 0;
					body_ovf = 1'b0;
				end else if (framing) begin
					if (b == close_sym) begin
						verdicts_due.push_back(judge_frame());
						framing  = 1'b0;
						body_len = 0;
						body_ovf = 1'b0;
					end else if (body_len < BODY_DEPTH) begin
						body_mem[body_len] = b;
						body_len++;
					end else begin
						body_ovf = 1'b1;
					end
				end
			end
			pending <= verdicts_due.size();
		end
	end

endmodule

// ===== sim/command_frame_validator_unit_tb.sv =====
// ------------------------------------------------------------------------
// command_frame_validator_unit_tb
// Byte-stream stimulus for the frame validator: directed frames for each
// status and corner, then mostly well-formed random frames with flaws and
// line noise, under several start/end symbol settings and random stalls
// on both streams. The checker next to the block judges every result.
// ------------------------------------------------------------------------
module command_frame_validator_unit_tb;
	import cfv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = '0;
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	reg_idx_t    cfg_index = REG_START;
	logic [7:0]  cfg_data  = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic        cfg_ready;
	int          mismatches;
	int          pending;

	byte_t open_sym  = START_RESET;
	byte_t close_sym = END_RESET;
	logic  idle_on   = 1'b1;

	localparam string BODY_CHARS = "APLRthc0123456789";

	command_frame_validator_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	command_frame_validator_unit_check u_frame_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic byte_t rand_body_byte();
		byte_t b;
		do begin
			if ($urandom_range(0, 1) == 0)
				b = BODY_CHARS[$urandom_range(0, BODY_CHARS.len() - 1)];
			else
				b = byte_t'($urandom_range(0, 255));
		end while (b == open_sym || b == close_sym);
		return b;
	endfunction

	initial begin
		int g;
		wait (arst_n);
		forever begin
			g = pick_gap();
			if (g == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	task automatic push_byte(input byte_t b);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame(input byte_t body [$]);
		push_byte(open_sym);
		foreach (body[i])
			push_byte(body[i]);
		push_byte(close_sym);
	endtask

	task automatic send_text(input string s);
		byte_t body [$];
		for (int i = 0; i < s.len(); i++)
			body.push_back(s[i]);
		send_frame(body);
	endtask

	// Hold the stream until every verdict has been returned, then let the
	// result path go quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input byte_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_START)
			open_sym = val;
		else
			close_sym = val;
	endtask

	// Well-formed command with a correct checksum, then maybe one flaw.
	task automatic build_command(ref byte_t q [$]);
		byte_t letters [4] = '{CHAR_A, CHAR_P, CHAR_L, CHAR_R};
		byte_t sensors [3] = '{CHAR_T, CHAR_H, CHAR_C};
		byte_t acc;
		byte_t s;
		int    cmd;
		int    v;
		int    flaw;
		cmd = $urandom_range(0, 3);
		q.push_back(letters[cmd]);
		acc = letters[cmd];
		if (cmd == 1) begin
			s = sensors[$urandom_range(0, 2)];
			q.push_back(s);
			acc = acc + s;
		end
		v = acc;
		if ($urandom_range(0, 3) == 0)
			v += 256 * $urandom_range(1, 2);
		flaw = $urandom_range(0, 11);
		if (flaw == 0)
			v = $urandom_range(0, 999);
		q.push_back(byte_t'(CHAR_0 + v / 100));
		q.push_back(byte_t'(CHAR_0 + (v / 10) % 10));
		q.push_back(byte_t'(CHAR_0 + v % 10));
		case (flaw)
			1: q[q.size() - 1 - $urandom_range(0, 2)] = rand_body_byte();
			2: if (cmd == 1) q[1] = rand_body_byte();
			3: void'(q.pop_back());
			4: q.push_back(byte_t'(CHAR_0 + $urandom_range(0, 9)));
			default: ;
		endcase
	endtask

	task automatic random_traffic(input int quota);
		byte_t body [$];
		int    sent;
		int    r;
		int    n;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 15) == 0)
				idle_on = !idle_on;
			body.delete();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				build_command(body);
				send_frame(body);
				sent += body.size() + 2;
			end else if (r < 82) begin
				n = $urandom_range(0, 11);
				repeat (n) body.push_back(rand_body_byte());
				send_frame(body);
				sent += n + 2;
			end else if (r < 90) begin
				// abandon a partial frame by reopening it
				push_byte(open_sym);
				n = $urandom_range(0, 5);
				repeat (n) push_byte(rand_body_byte());
				build_command(body);
				send_frame(body);
				sent += n + body.size() + 3;
			end else if (r < 95) begin
				push_byte(close_sym);
			end else begin
				repeat ($urandom_range(1, 4))
					push_byte(byte_t'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		byte_t other;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("A065");
		send_text("Ph184");
		send_text("Pt196");
		send_text("Pc179");
		send_text("L077");
		send_text("R08x");
		send_text("Px123");
		send_text("");
		send_text("Z065");
		send_text("A321");
		send_text("A0650");
		send_text("AAAAAAAAAB");
		push_byte(open_sym);
		push_byte(CHAR_L);
		send_text("R999");
		push_byte(close_sym);
		push_byte(8'h00);
		push_byte(8'hFF);
		settle();

		random_traffic(300);
		settle();
		set_reg(REG_START, 8'h00);
		set_reg(REG_END, 8'hFF);
		random_traffic(250);
		settle();
		set_reg(REG_START, 8'hFF);
		set_reg(REG_END, 8'h00);
		random_traffic(250);
		settle();
		// one symbol for both: every such byte reopens, nothing closes
		set_reg(REG_START, 8'h7E);
		set_reg(REG_END, 8'h7E);
		random_traffic(40);
		settle();
		other = byte_t'($urandom_range(0, 255));
		set_reg(REG_START, other);
		do other = byte_t'($urandom_range(0, 255)); while (other == open_sym);
		set_reg(REG_END, other);
		random_traffic(250);
		settle();
		set_reg(REG_START, START_RESET);
		set_reg(REG_END, END_RESET);
		random_traffic(150);
		settle();

		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
